// File: hdl/wildcard_byte_pattern_scan_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the wildcard byte pattern scan unit
// Concurrent assertion wrappers, with and without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_BYTE_PATTERN_SCAN_UNIT_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_UNIT_MACROS_SVH

// checked only while out of reset
`define WBPS_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every rising edge
`define WBPS_ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/wbps_pkg.sv
// ----------------------------------------------------------------------------
// Wildcard byte pattern scan package
// Shared constants, register indexes and types.
// ----------------------------------------------------------------------------
package wbps_pkg;

    localparam int MAX_PATTERN_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;

    localparam int SIG_BYTES    = 16;
    localparam int SIG_IDX_BITS = 4;
    localparam int LEN_BITS     = 5;
    localparam int CFG_W        = 64;
    localparam int CFG_IDX_BITS = 2;
    localparam int OUT_BITS     = 32;
    localparam int COUNT_BITS   = 32;

    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_PATTERN_LOW  = 2'd0;
    localparam t_cfg_idx CFG_PATTERN_HIGH = 2'd1;
    localparam t_cfg_idx CFG_CARE_MASK    = 2'd2;
    localparam t_cfg_idx CFG_PATTERN_LEN  = 2'd3;

    typedef logic [7:0]                 t_byte;
    typedef logic [SIG_BYTES-1:0][7:0]  t_sig;
    typedef logic [SIG_BYTES-1:0]       t_care;
    typedef logic [LEN_BITS-1:0]        t_len;
    typedef logic [OUT_BITS-1:0]        t_out_word;

    typedef struct packed {
        logic load;
        logic clear;
    } t_shift_ctl;

endpackage

// File: hdl/wbps_in_if.sv
// ----------------------------------------------------------------------------
// Scan input channel
// Valid/ready channel carrying one data byte and its region start flag.
// ----------------------------------------------------------------------------
interface wbps_in_if import wbps_pkg::*; ();

    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  region_start;

    modport source (output valid, output data_byte, output region_start, input ready);
    modport sink   (input valid, input data_byte, input region_start, output ready);

endinterface

// File: hdl/wbps_out_if.sv
// ----------------------------------------------------------------------------
// Scan result channel
// Valid/ready channel carrying the per-byte match report.
// ----------------------------------------------------------------------------
interface wbps_out_if import wbps_pkg::*; ();

    logic      valid;
    logic      ready;
    logic      match_here;
    t_out_word match_offset;
    t_out_word match_total;
    logic      first_found;
    t_out_word first_offset;

    modport source (output valid, output match_here, output match_offset,
                    output match_total, output first_found, output first_offset,
                    input ready);
    modport sink   (input valid, input match_here, input match_offset,
                    input match_total, input first_found, input first_offset,
                    output ready);

endinterface

// File: hdl/wbps_cell.sv
// ----------------------------------------------------------------------------
// Scan history cell
// Holds one history byte, shifts it on to its neighbour on each item and
// compares the shifted-in byte against the signature byte aligned to it.
// ----------------------------------------------------------------------------
module wbps_cell import wbps_pkg::*; #(
    parameter int CELL_IDX = 0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_shift_ctl i_ctl,
    input  t_byte      i_prev_byte,
    input  t_sig       i_sig,
    input  t_care      i_care,
    input  t_len       i_len,
    output t_byte      o_byte,
    output logic       o_ok
);

    t_byte               r_byte;
    t_byte               n_byte;
    logic                in_use;
    logic [LEN_BITS:0]   pos_full;
    logic [SIG_IDX_BITS-1:0] pos;
    logic                must_cmp;

    always_comb begin
        if ((CELL_IDX != 0) && i_ctl.clear) begin
            n_byte = '0;
        end else begin
            n_byte = i_prev_byte;
        end
    end

    // signature position that lines up with this history slot
    always_comb begin
        in_use   = (int'(i_len) > CELL_IDX);
        pos_full = {1'b0, i_len} - (LEN_BITS+1)'(CELL_IDX + 1);
        pos      = pos_full[SIG_IDX_BITS-1:0];
        must_cmp = in_use && (pos_full < (LEN_BITS+1)'(SIG_BYTES)) && i_care[pos];
        o_ok     = !must_cmp || (n_byte == i_sig[pos]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else if (i_ctl.load) begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

// File: hdl/wildcard_byte_pattern_scan_unit.sv
// ----------------------------------------------------------------------------
// Wildcard byte pattern scan unit
// Result: registered, it appears in the cycle after the byte is taken.
// Throughput: 1 byte per cycle while the result drains; all history cells compare in parallel.
// Input is taken while the result register is empty or being drained.
// Reset: synchronous, clears config, history, counters and the result valid flag.
// Matches a masked byte signature against a shifting row of history cells and
// tracks the region offset, saturating match count and first match offset.
// ----------------------------------------------------------------------------
`include "wildcard_byte_pattern_scan_unit_macros.svh"

module wildcard_byte_pattern_scan_unit import wbps_pkg::*; #(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    wbps_in_if.sink           i_in,
    wbps_out_if.source        o_out,
    input  logic              i_cfg_we,
    input  t_cfg_idx          i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_wdata
);

    t_sig  r_pat;
    t_care r_care;
    t_len  r_len;

    logic [OFFSET_BITS-1:0] r_seen;
    logic [COUNT_BITS-1:0]  r_count;
    logic                   r_first_valid;
    logic [OFFSET_BITS-1:0] r_first_pos;

    logic      r_out_valid;
    logic      r_match_here;
    t_out_word r_match_offset;
    t_out_word r_match_total;
    logic      r_first_found;
    t_out_word r_first_offset;

    logic                   accept;
    t_shift_ctl             ctl;
    t_len                   len_use;
    logic [OFFSET_BITS-1:0] here;
    logic [OFFSET_BITS-1:0] n_seen;
    logic [OFFSET_BITS-1:0] n_start;
    logic [COUNT_BITS-1:0]  count_base;
    logic [COUNT_BITS-1:0]  n_count;
    logic                   first_base;
    logic [OFFSET_BITS-1:0] first_pos_base;
    logic                   n_first_valid;
    logic [OFFSET_BITS-1:0] n_first_pos;
    logic                   hit;

    t_byte                  cell_byte [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] cell_ok;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_care <= '0;
            r_len  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PATTERN_LOW:  r_pat[SIG_BYTES/2-1:0]         <= i_cfg_wdata;
                CFG_PATTERN_HIGH: r_pat[SIG_BYTES-1:SIG_BYTES/2] <= i_cfg_wdata;
                CFG_CARE_MASK:    r_care <= i_cfg_wdata[SIG_BYTES-1:0];
                CFG_PATTERN_LEN:  r_len  <= i_cfg_wdata[LEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign i_in.ready = i_rst_n && (!r_out_valid || o_out.ready);
    assign accept     = i_in.valid && i_in.ready;

    assign ctl.load  = accept;
    assign ctl.clear = i_in.region_start;

    assign len_use = (int'(r_len) > MAX_PATTERN) ? LEN_BITS'(MAX_PATTERN) : r_len;

    // history row
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        t_byte prev_byte;
        if (k == 0) begin : g_head
            assign prev_byte = i_in.data_byte;
        end else begin : g_link
            assign prev_byte = cell_byte[k-1];
        end
        wbps_cell #(
            .CELL_IDX (k)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_prev_byte (prev_byte),
            .i_sig       (r_pat),
            .i_care      (r_care),
            .i_len       (len_use),
            .o_byte      (cell_byte[k]),
            .o_ok        (cell_ok[k])
        );
    end

    // region tracking
    always_comb begin
        here           = i_in.region_start ? '0 : r_seen;
        count_base     = i_in.region_start ? '0 : r_count;
        first_base     = i_in.region_start ? 1'b0 : r_first_valid;
        first_pos_base = i_in.region_start ? '0 : r_first_pos;

        n_seen  = (here != '1) ? here + OFFSET_BITS'(1) : here;
        n_start = here - OFFSET_BITS'(len_use) + OFFSET_BITS'(1);

        hit = (len_use != '0) && (n_seen >= OFFSET_BITS'(len_use)) && (&cell_ok);

        n_count       = count_base;
        n_first_valid = first_base;
        n_first_pos   = first_pos_base;
        if (hit) begin
            if (count_base != '1) begin
                n_count = count_base + COUNT_BITS'(1);
            end
            if (!first_base) begin
                n_first_valid = 1'b1;
                n_first_pos   = n_start;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen        <= '0;
            r_count       <= '0;
            r_first_valid <= 1'b0;
            r_first_pos   <= '0;
        end else if (accept) begin
            r_seen        <= n_seen;
            r_count       <= n_count;
            r_first_valid <= n_first_valid;
            r_first_pos   <= n_first_pos;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_match_here   <= hit;
            r_match_offset <= hit ? OUT_BITS'(n_start) : '0;
            r_match_total  <= OUT_BITS'(n_count);
            r_first_found  <= n_first_valid;
            r_first_offset <= OUT_BITS'(n_first_pos);
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.match_here   = r_match_here;
    assign o_out.match_offset = r_match_offset;
    assign o_out.match_total  = r_match_total;
    assign o_out.first_found  = r_first_found;
    assign o_out.first_offset = r_first_offset;

    `WBPS_ASSERT_RST(a_first_has_count, i_clk, i_rst_n, r_first_valid |-> (r_count != '0), "first match recorded with zero count")
    `WBPS_ASSERT_RST(a_hit_bumps_count, i_clk, i_rst_n, (i_rst_n && accept && hit && !i_in.region_start && (r_count != '1)) |=> (r_count == $past(r_count) + COUNT_BITS'(1)), "match did not advance count")
    `WBPS_ASSERT_RST(a_seen_advances, i_clk, i_rst_n, (i_rst_n && accept) |=> (r_seen != '0), "byte count zero after an item")
    `WBPS_ASSERT_RST(a_hit_implies_first, i_clk, i_rst_n, (r_out_valid && r_match_here) |-> r_first_found, "match reported without first match")
    `WBPS_ASSERT_CLK(a_reset_empties, i_clk, !i_rst_n |=> !r_out_valid, "result register not empty after reset")

endmodule

// File: tb/sv/wildcard_byte_pattern_scan_unit_test.sv
// ----------------------------------------------------------------------------
// Wildcard byte pattern scan unit testbench
// Streams bytes into the scan unit under several signatures, predicts each
// per-byte match report in step with the input and checks every report as it
// leaves. Directed items cover the extremes first, then random phases plant
// whole, broken and noisy copies of the signature under random flow control.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scan_unit_test;
    import wbps_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_BYTES = 850;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC,
        STALL_BURSTS
    } t_stall_mode;

    typedef struct packed {
        logic      match_here;
        t_out_word match_offset;
        t_out_word match_total;
        logic      first_found;
        t_out_word first_offset;
    } t_scan_report;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    t_cfg_idx         i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_wdata;

    wbps_in_if  in_if();
    wbps_out_if out_if();

    wildcard_byte_pattern_scan_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // signature as last loaded
    t_sig  sig_cfg;
    t_care care_cfg;
    t_len  len_cfg;

    // scan state mirror
    t_sig        hist;
    logic [31:0] seen;
    logic [31:0] total_q;
    logic        found_q;
    logic [31:0] first_q;

    t_scan_report expected_reports[$];
    t_scan_report report_due;
    t_byte        planted[$];

    int  failures;
    int  bytes_sent;
    int  matches_seen;
    int  configs_loaded;
    int  burst_left;
    bit  gaps_on;
    int  quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_scan_report scan_byte(input t_byte b, input logic rs);
        t_scan_report r;
        logic [31:0]  here;
        logic [31:0]  start;
        logic         hit;
        int           len;
        if (rs) begin
            hist    = '0;
            seen    = '0;
            total_q = '0;
            found_q = 1'b0;
            first_q = '0;
        end
        here = seen;
        hist = {hist[SIG_BYTES-2:0], b};
        if (seen != '1)
            seen++;
        len   = (len_cfg > SIG_BYTES) ? SIG_BYTES : int'(len_cfg);
        hit   = 1'b0;
        start = '0;
        if (len != 0 && seen >= 32'(len)) begin
            hit = 1'b1;
            for (int i = 0; i < len; i++) begin
                if (care_cfg[i] && hist[len-1-i] != sig_cfg[i])
                    hit = 1'b0;
            end
            if (hit)
                start = here - 32'(len - 1);
        end
        if (hit) begin
            if (total_q != '1)
                total_q++;
            if (!found_q) begin
                found_q = 1'b1;
                first_q = start;
            end
        end
        r.match_here   = hit;
        r.match_offset = start;
        r.match_total  = total_q;
        r.first_found  = found_q;
        r.first_offset = first_q;
        return r;
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            failures++;
        end
    endfunction

    // queue a whole, broken or noise run of bytes
    function automatic void plant_bytes();
        int len;
        int pick;
        int j;
        len  = (len_cfg > SIG_BYTES) ? SIG_BYTES : int'(len_cfg);
        pick = $urandom_range(0, 19);
        if (len == 0 || pick < 5) begin
            repeat ($urandom_range(1, 4))
                planted.insert(planted.size(), t_byte'($urandom));
        end else begin
            for (int i = 0; i < len; i++)
                planted.insert(planted.size(),
                               care_cfg[i] ? sig_cfg[i] : t_byte'($urandom));
            if (pick < 8) begin
                j = planted.size() - 1 - $urandom_range(0, len - 1);
                planted[j] = planted[j] ^ t_byte'(1 << $urandom_range(0, 7));
            end
        end
    endfunction

    task automatic push_byte(input t_byte b, input logic rs);
        t_scan_report rep;
        if (gaps_on && burst_left == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0)
            burst_left--;
        in_if.valid        <= 1'b1;
        in_if.data_byte    <= b;
        in_if.region_start <= rs;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        rep = scan_byte(b, rs);
        expected_reports.insert(expected_reports.size(), rep);
        bytes_sent++;
    endtask

    task automatic settle_scan();
        in_if.valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic load_signature(input logic [63:0] lo, input logic [63:0] hi,
                                  input logic [63:0] care_word, input logic [63:0] len_word);
        settle_scan();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_PATTERN_LOW;
        i_cfg_wdata <= lo;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_PATTERN_HIGH;
        i_cfg_wdata <= hi;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_CARE_MASK;
        i_cfg_wdata <= care_word;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_PATTERN_LEN;
        i_cfg_wdata <= len_word;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sig_cfg  = {hi, lo};
        care_cfg = care_word[SIG_BYTES-1:0];
        len_cfg  = len_word[LEN_BITS-1:0];
        configs_loaded++;
    endtask

    // bytes before any region start, first under the empty reset signature
    task automatic test_unframed_region();
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        load_signature(64'h55AA, 64'h0, 64'h3, 64'd2);
        push_byte(8'hAA, 1'b0);
        push_byte(8'h55, 1'b0);
        push_byte(8'hAA, 1'b0);
        push_byte(8'h55, 1'b0);
    endtask

    // all-wildcard signature: match only once enough bytes are in
    task automatic test_short_region();
        load_signature({$urandom, $urandom}, {$urandom, $urandom}, 64'h0, 64'd3);
        push_byte(8'h11, 1'b1);
        push_byte(8'h22, 1'b0);
        push_byte(8'h33, 1'b0);
        push_byte(8'h44, 1'b1);
    endtask

    // length beyond the signature size clamps to 16, first and last byte compared
    task automatic test_long_length();
        load_signature(64'h0, {8'hFF, 56'(64'h0123_4567_89AB_CDEF)}, 64'h8001, 64'h1F);
        push_byte(8'h00, 1'b1);
        repeat (SIG_BYTES - 2)
            push_byte(t_byte'($urandom), 1'b0);
        push_byte(8'hFF, 1'b0);
    endtask

    task automatic test_random_scan(input int target);
        logic [63:0] care_word;
        logic [63:0] len_word;
        logic [63:0] junk;
        t_len        len5;
        int          pick;
        int          n;
        while (bytes_sent < target) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:       len5 = 5'd0;
                1:       len5 = 5'd16;
                2:       len5 = t_len'($urandom_range(17, 31));
                default: len5 = t_len'($urandom_range(1, 6));
            endcase
            junk = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'h0;
            pick = $urandom_range(0, 9);
            care_word = {junk[63:16], (pick < 3) ? 16'hFFFF : (pick == 3) ? 16'h0000
                                                            : 16'($urandom)};
            len_word  = {junk[63:LEN_BITS], len5};
            load_signature({$urandom, $urandom}, {$urandom, $urandom}, care_word, len_word);
            planted.delete();
            gaps_on = ($urandom_range(0, 3) != 0);
            n = $urandom_range(50, 90);
            repeat (n) begin
                if (planted.size() == 0)
                    plant_bytes();
                push_byte(planted.pop_front(), ($urandom_range(0, 39) == 0));
            end
        end
    endtask

    // receiver stall pattern
    initial begin
        t_stall_mode mode;
        int          left;
        int          hold;
        out_if.ready <= 1'b0;
        mode = STALL_NONE;
        left = 0;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (left == 0) begin
                mode = t_stall_mode'($urandom_range(0, 3));
                left = $urandom_range(40, 200);
                hold = 0;
            end
            left--;
            case (mode)
                STALL_NONE:     out_if.ready <= 1'b1;
                STALL_RANDOM:   out_if.ready <= 1'($urandom_range(0, 1));
                STALL_PERIODIC: out_if.ready <= ((left % 7) > 2);
                STALL_BURSTS: begin
                    if (hold > 0) begin
                        hold--;
                        out_if.ready <= 1'b0;
                    end else if ($urandom_range(0, 15) == 0) begin
                        hold = $urandom_range(4, 24);
                        out_if.ready <= 1'b0;
                    end else begin
                        out_if.ready <= 1'b1;
                    end
                end
                default:        out_if.ready <= 1'b1;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (expected_reports.size() == 0) begin
                $display("%0t: report with no item pending, expected none, actual %0h %0h",
                         $time, out_if.match_here, out_if.match_offset);
                failures++;
            end else begin
                report_due = expected_reports.pop_front();
                check_field("match_here",   32'(report_due.match_here),  32'(out_if.match_here));
                check_field("match_offset", report_due.match_offset,     out_if.match_offset);
                check_field("match_total",  report_due.match_total,      out_if.match_total);
                check_field("first_found",  32'(report_due.first_found), 32'(out_if.first_found));
                check_field("first_offset", report_due.first_offset,     out_if.first_offset);
                if (out_if.match_here === 1'b1)
                    matches_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
            (out_if.valid === 1'b1 && out_if.ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
            $display("FAIL wildcard_byte_pattern_scan_unit");
            $finish;
        end
    end

    initial begin
        failures       = 0;
        bytes_sent     = 0;
        matches_seen   = 0;
        configs_loaded = 0;
        burst_left     = 0;
        gaps_on        = 1'b1;
        quiet_cycles   = 0;
        sig_cfg  = '0;
        care_cfg = '0;
        len_cfg  = '0;
        hist     = '0;
        seen     = '0;
        total_q  = '0;
        found_q  = 1'b0;
        first_q  = '0;
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= CFG_PATTERN_LOW;
        i_cfg_wdata        <= '0;
        in_if.valid        <= 1'b0;
        in_if.data_byte    <= '0;
        in_if.region_start <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_unframed_region();
        test_short_region();
        test_long_length();
        test_random_scan(bytes_sent + RANDOM_BYTES);

        settle_scan();
        repeat (4) @(posedge i_clk);
        $display("Scanned %0d bytes under %0d signature loads; %0d matching windows reported.",
                 bytes_sent, configs_loaded, matches_seen);
        if (failures == 0) begin
            $display("PASS wildcard_byte_pattern_scan_unit");
        end else begin
            $display("%0d mismatches", failures);
            $display("FAIL wildcard_byte_pattern_scan_unit");
        end
        $finish;
    end

endmodule
